/* hw/rtl/ocp_pkg.sv */
// ocp_pkg: shared types and constants for the occupation-string parity block
// no dependencies

package ocp_pkg;

  localparam int DATA_W  = 64;
  localparam int POP_W   = 7;
  localparam int CNT_W   = 10;
  localparam int POS_W   = 3;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified word, as handed from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] ann;
    logic [DATA_W-1:0] cre;
    logic [DATA_W-1:0] com;
    logic [POP_W-1:0]  ann_cnt;
    logic [POP_W-1:0]  cre_cnt;
    logic              ops_odd;
    logic              below_odd;
    logic              com_odd;
    logic              last;
  } entry_t;

endpackage

/* hw/rtl/ocp_front.sv */
// ocp_front: splits one word pair into masks, popcounts and local parities
// depends on ocp_pkg

module ocp_front #(
  parameter int WORD_BITS = 64
) (
  input  logic [63:0]     source_word,
  input  logic [63:0]     target_word,
  input  logic            final_word,
  output ocp_pkg::entry_t entry
);

  localparam logic [ocp_pkg::DATA_W-1:0] WORD_MASK =
    {ocp_pkg::DATA_W{1'b1}} >> (ocp_pkg::DATA_W - WORD_BITS);

  logic [ocp_pkg::DATA_W-1:0] s;
  logic [ocp_pkg::DATA_W-1:0] t;
  logic [ocp_pkg::DATA_W-1:0] ann;
  logic [ocp_pkg::DATA_W-1:0] cre;
  logic [ocp_pkg::DATA_W-1:0] com;
  logic [ocp_pkg::DATA_W-1:0] ops;
  logic [ocp_pkg::DATA_W-1:0] below;

  always_comb begin
    s   = source_word & WORD_MASK;
    t   = target_word & WORD_MASK;
    ann = s & ~t;
    cre = t & ~s;
    com = s & t;
    ops = ann | cre;
    // exclusive prefix parity of the common bits
    below = com << 1;
    below = below ^ (below << 1);
    below = below ^ (below << 2);
    below = below ^ (below << 4);
    below = below ^ (below << 8);
    below = below ^ (below << 16);
    below = below ^ (below << 32);

    entry.ann       = ann;
    entry.cre       = cre;
    entry.com       = com;
    entry.ann_cnt   = ocp_pkg::POP_W'($countones(ann));
    entry.cre_cnt   = ocp_pkg::POP_W'($countones(cre));
    entry.ops_odd   = ^ops;
    entry.below_odd = ^(ops & below);
    entry.com_odd   = ^com;
    entry.last      = final_word;
  end

endmodule

/* hw/rtl/ocp_queue.sv */
// ocp_queue: short register queue between the front and the back
// depends on ocp_pkg

module ocp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ocp_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output ocp_pkg::entry_t pop_data
);

  ocp_pkg::entry_t slots [ocp_pkg::QUEUE_DEPTH];
  logic [ocp_pkg::QPTR_W-1:0] wr_ptr;
  logic [ocp_pkg::QPTR_W-1:0] rd_ptr;
  logic [ocp_pkg::QCNT_W-1:0] count;

  function automatic logic [ocp_pkg::QPTR_W-1:0] bump(input logic [ocp_pkg::QPTR_W-1:0] p);
    if (p == ocp_pkg::QPTR_W'(ocp_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full     = (count == ocp_pkg::QCNT_W'(ocp_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/ocp_back.sv */
// ocp_back: running counts, parity, word index and the result register
// depends on ocp_pkg

module ocp_back #(
  parameter int MAX_WORDS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                entry_valid,
  input  ocp_pkg::entry_t                     entry,
  output logic                                entry_take,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [ocp_pkg::POS_W-1:0]           word_position,
  output logic [ocp_pkg::DATA_W-1:0]          annihilate_mask,
  output logic [ocp_pkg::DATA_W-1:0]          create_mask,
  output logic [ocp_pkg::DATA_W-1:0]          common_mask,
  output logic [ocp_pkg::CNT_W-1:0]           annihilate_total,
  output logic [ocp_pkg::CNT_W-1:0]           create_total,
  output logic                                phase_odd,
  output logic                                result_last
);

  localparam int CW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic                        common_parity;
  logic                        phase_acc;
  logic [CW-1:0]               word_counter;
  logic [ocp_pkg::CNT_W-1:0]   ann_count;
  logic [ocp_pkg::CNT_W-1:0]   cre_count;

  logic                        phase_next;
  logic                        common_parity_next;
  logic [CW-1:0]               word_counter_next;
  logic [ocp_pkg::CNT_W-1:0]   ann_count_next;
  logic [ocp_pkg::CNT_W-1:0]   cre_count_next;
  logic [ocp_pkg::CNT_W:0]     ann_sum;
  logic [ocp_pkg::CNT_W:0]     cre_sum;
  logic [CW:0]                 counter_inc;
  logic [CW+2:0]               pos_ext;

  assign entry_take = entry_valid && (!result_valid || result_ready);

  always_comb begin
    ann_sum = {1'b0, ann_count} + (ocp_pkg::CNT_W + 1)'(entry.ann_cnt);
    cre_sum = {1'b0, cre_count} + (ocp_pkg::CNT_W + 1)'(entry.cre_cnt);
    ann_count_next = ann_sum[ocp_pkg::CNT_W] ? ocp_pkg::COUNT_MAX
                                             : ann_sum[ocp_pkg::CNT_W-1:0];
    cre_count_next = cre_sum[ocp_pkg::CNT_W] ? ocp_pkg::COUNT_MAX
                                             : cre_sum[ocp_pkg::CNT_W-1:0];
    phase_next = phase_acc ^ (entry.ops_odd & common_parity) ^ entry.below_odd;
    common_parity_next = common_parity ^ entry.com_odd;
    counter_inc = {1'b0, word_counter} + 1'b1;
    if (counter_inc >= (CW + 1)'(MAX_WORDS)) begin
      word_counter_next = '0;
    end else begin
      word_counter_next = counter_inc[CW-1:0];
    end
    pos_ext = (CW + 3)'(word_counter);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      common_parity <= 1'b0;
      phase_acc     <= 1'b0;
      word_counter  <= '0;
      ann_count     <= '0;
      cre_count     <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (entry_take) begin
        result_valid <= 1'b1;
        if (entry.last) begin
          common_parity <= 1'b0;
          phase_acc     <= 1'b0;
          word_counter  <= '0;
          ann_count     <= '0;
          cre_count     <= '0;
        end else begin
          common_parity <= common_parity_next;
          phase_acc     <= phase_next;
          word_counter  <= word_counter_next;
          ann_count     <= ann_count_next;
          cre_count     <= cre_count_next;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_take) begin
      word_position    <= pos_ext[ocp_pkg::POS_W-1:0];
      annihilate_mask  <= entry.ann;
      create_mask      <= entry.cre;
      common_mask      <= entry.com;
      annihilate_total <= ann_count_next;
      create_total     <= cre_count_next;
      phase_odd        <= phase_next;
      result_last      <= entry.last;
    end
  end

endmodule

/* hw/rtl/onv_connection_parity.sv */
// onv_connection_parity: excitation masks, running counts and permutation parity
// depends on ocp_pkg, ocp_front, ocp_queue, ocp_back
//
//   channel  handshake                    payload
//   item     item_valid / item_ready      source_word, target_word, final_word
//   result   result_valid / result_ready  word_position, three masks, totals,
//                                         phase_odd, result_last
//
// one item per cycle sustained while result_ready stays high; an accepted item is registered in turn
// (front into the two-entry queue, back into the result register)
// item_ready drops only when the queue is full, i.e. after the result side stalls
// rst is synchronous and clears the queue, the running state and result_valid
// running state returns to zero after each item flagged final_word

module onv_connection_parity #(
  parameter int MAX_WORDS = 8,
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [63:0] source_word,
  input  logic [63:0] target_word,
  input  logic        final_word,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  word_position,
  output logic [63:0] annihilate_mask,
  output logic [63:0] create_mask,
  output logic [63:0] common_mask,
  output logic [9:0]  annihilate_total,
  output logic [9:0]  create_total,
  output logic        phase_odd,
  output logic        result_last
);

  ocp_pkg::entry_t front_entry;
  ocp_pkg::entry_t queue_entry;
  logic            queue_full;
  logic            queue_nonempty;
  logic            queue_pop;

  assign item_ready = !queue_full;

  ocp_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .source_word (source_word),
    .target_word (target_word),
    .final_word  (final_word),
    .entry       (front_entry)
  );

  ocp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && item_ready),
    .push_data (front_entry),
    .full      (queue_full),
    .pop       (queue_pop),
    .nonempty  (queue_nonempty),
    .pop_data  (queue_entry)
  );

  ocp_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .entry_valid      (queue_nonempty),
    .entry            (queue_entry),
    .entry_take       (queue_pop),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .word_position    (word_position),
    .annihilate_mask  (annihilate_mask),
    .create_mask      (create_mask),
    .common_mask      (common_mask),
    .annihilate_total (annihilate_total),
    .create_total     (create_total),
    .phase_odd        (phase_odd),
    .result_last      (result_last)
  );

endmodule

/* sim/onv_parity_checker.sv */
// onv_parity_checker: watches both channels of onv_connection_parity, predicts each result
// from the accepted items and compares field by field; depends on ocp_pkg only

module onv_parity_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  logic [ocp_pkg::DATA_W-1:0] source_word,
  input  logic [ocp_pkg::DATA_W-1:0] target_word,
  input  logic                       final_word,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic [ocp_pkg::POS_W-1:0]  word_position,
  input  logic [ocp_pkg::DATA_W-1:0] annihilate_mask,
  input  logic [ocp_pkg::DATA_W-1:0] create_mask,
  input  logic [ocp_pkg::DATA_W-1:0] common_mask,
  input  logic [ocp_pkg::CNT_W-1:0]  annihilate_total,
  input  logic [ocp_pkg::CNT_W-1:0]  create_total,
  input  logic                       phase_odd,
  input  logic                       result_last,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS_PER_STRING = 8;

  typedef struct packed {
    logic [ocp_pkg::POS_W-1:0]  pos;
    logic [ocp_pkg::DATA_W-1:0] ann;
    logic [ocp_pkg::DATA_W-1:0] cre;
    logic [ocp_pkg::DATA_W-1:0] com;
    logic [ocp_pkg::CNT_W-1:0]  ann_total;
    logic [ocp_pkg::CNT_W-1:0]  cre_total;
    logic                       odd;
    logic                       last;
  } word_result_t;

  word_result_t     expected_words[$];

  logic                      common_odd;
  logic                      phase_acc;
  logic [ocp_pkg::POS_W-1:0] next_pos;
  logic [ocp_pkg::CNT_W-1:0] ann_run;
  logic [ocp_pkg::CNT_W-1:0] cre_run;

  function automatic void clear_string();
    common_odd = 1'b0;
    phase_acc  = 1'b0;
    next_pos   = '0;
    ann_run    = '0;
    cre_run    = '0;
  endfunction

  function automatic logic [ocp_pkg::CNT_W-1:0] sat_sum(logic [ocp_pkg::CNT_W-1:0] a, int b);
    int s;
    s = int'(a) + b;
    return (s > int'(ocp_pkg::COUNT_MAX)) ? ocp_pkg::COUNT_MAX : s[ocp_pkg::CNT_W-1:0];
  endfunction

  function automatic word_result_t predict_word(logic [ocp_pkg::DATA_W-1:0] s,
                                                logic [ocp_pkg::DATA_W-1:0] t,
                                                logic fin);
    word_result_t r;
    logic [ocp_pkg::DATA_W-1:0] ops;
    logic run_odd;
    logic flips;
    r.ann  = s & ~t;
    r.cre  = t & ~s;
    r.com  = s & t;
    r.pos  = next_pos;
    r.last = fin;
    ops = r.ann | r.cre;
    // each operator passes the common bits below it within the word
    run_odd = 1'b0;
    flips   = 1'b0;
    for (int i = 0; i < ocp_pkg::DATA_W; i++) begin
      flips   ^= ops[i] & run_odd;
      run_odd ^= r.com[i];
    end
    // and all common bits of earlier words
    phase_acc  ^= flips ^ (($countones(ops) % 2 == 1) & common_odd);
    common_odd ^= run_odd;
    ann_run = sat_sum(ann_run, $countones(r.ann));
    cre_run = sat_sum(cre_run, $countones(r.cre));
    r.ann_total = ann_run;
    r.cre_total = cre_run;
    r.odd = phase_acc;
    next_pos = (int'(next_pos) + 1 >= WORDS_PER_STRING) ? '0 : next_pos + 1'b1;
    if (fin) clear_string();
    return r;
  endfunction

  function automatic void check_field(string name, logic [ocp_pkg::DATA_W-1:0] exp,
                                      logic [ocp_pkg::DATA_W-1:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    word_result_t e;
    if (rst) begin
      clear_string();
      expected_words.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          e = expected_words.pop_front();
          check_field("word_position", ocp_pkg::DATA_W'(e.pos),
                      ocp_pkg::DATA_W'(word_position));
          check_field("annihilate_mask", e.ann, annihilate_mask);
          check_field("create_mask", e.cre, create_mask);
          check_field("common_mask", e.com, common_mask);
          check_field("annihilate_total", ocp_pkg::DATA_W'(e.ann_total),
                      ocp_pkg::DATA_W'(annihilate_total));
          check_field("create_total", ocp_pkg::DATA_W'(e.cre_total),
                      ocp_pkg::DATA_W'(create_total));
          check_field("phase_odd", ocp_pkg::DATA_W'(e.odd), ocp_pkg::DATA_W'(phase_odd));
          check_field("result_last", ocp_pkg::DATA_W'(e.last),
                      ocp_pkg::DATA_W'(result_last));
        end
      end
      if (item_valid && item_ready)
        expected_words.push_back(predict_word(source_word, target_word, final_word));
    end
    pending = expected_words.size();
  end

endmodule

/* sim/tb_onv_connection_parity.sv */
// tb_onv_connection_parity: stimulus and verdict for onv_connection_parity
// depends on ocp_pkg, the block's rtl and onv_parity_checker

module tb_onv_connection_parity;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_AFTER   = 390;
  localparam int DW           = ocp_pkg::DATA_W;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_ready;
  logic [DW-1:0]              source_word = '0;
  logic [DW-1:0]              target_word = '0;
  logic                       final_word = 1'b0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic [ocp_pkg::POS_W-1:0]  word_position;
  logic [DW-1:0]              annihilate_mask;
  logic [DW-1:0]              create_mask;
  logic [DW-1:0]              common_mask;
  logic [ocp_pkg::CNT_W-1:0]  annihilate_total;
  logic [ocp_pkg::CNT_W-1:0]  create_total;
  logic                       phase_odd;
  logic                       result_last;

  int errors;
  int pending;
  int sent = 0;
  bit calm = 1'b0;
  bit gappy = 1'b0;

  always #4 clk = ~clk;

  onv_connection_parity i_dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .source_word     (source_word),
    .target_word     (target_word),
    .final_word      (final_word),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .word_position   (word_position),
    .annihilate_mask (annihilate_mask),
    .create_mask     (create_mask),
    .common_mask     (common_mask),
    .annihilate_total(annihilate_total),
    .create_total    (create_total),
    .phase_odd       (phase_odd),
    .result_last     (result_last)
  );

  onv_parity_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .source_word     (source_word),
    .target_word     (target_word),
    .final_word      (final_word),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .word_position   (word_position),
    .annihilate_mask (annihilate_mask),
    .create_mask     (create_mask),
    .common_mask     (common_mask),
    .annihilate_total(annihilate_total),
    .create_total    (create_total),
    .phase_odd       (phase_odd),
    .result_last     (result_last),
    .errors          (errors),
    .pending         (pending)
  );

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [DW-1:0] s, input logic [DW-1:0] t,
                           input logic fin);
    item_valid  <= 1'b1;
    source_word <= s;
    target_word <= t;
    final_word  <= fin;
    do @(posedge clk); while (!item_ready);
    sent++;
    @(negedge clk);
    if (gappy && !calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: return {{(DW-1){1'b0}}, 1'b1} << $urandom_range(0, DW - 1);
      4: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_partner(logic [DW-1:0] s);
    case ($urandom_range(0, 5))
      0: return s;
      1: return ~s;
      2: return s ^ ({{(DW-1){1'b0}}, 1'b1} << $urandom_range(0, DW - 1));
      3: return s ^ ({$urandom, $urandom} & {$urandom, $urandom});
      default: return pick_word();
    endcase
  endfunction

  // result side: random stall bursts, with busy and quiet windows
  initial begin
    int stall_left;
    bit busy;
    stall_left = 0;
    busy = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) busy = ($urandom_range(0, 2) != 0);
      if (calm || !busy) begin
        result_ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [DW-1:0] s;
    logic [DW-1:0] t;
    int len;
    int kind;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty strings, full overlap, single bit ends, alternating bits
    send_word('0, '0, 1'b1);
    send_word('1, '1, 1'b1);
    send_word('1, '0, 1'b1);
    send_word({1'b1, {(DW-1){1'b0}}}, {{(DW-1){1'b0}}, 1'b1}, 1'b1);
    send_word({(DW/2){2'b10}}, {(DW/2){2'b01}}, 1'b1);
    send_word({(DW/2){2'b10}}, '1, 1'b1);
    // overlong string: word position wraps twice, annihilate count saturates
    repeat (16) send_word('1, '0, 1'b0);
    send_word('0, '1, 1'b0);
    send_word('1, '1, 1'b1);

    while (sent < RANDOM_ITEMS) begin
      if (sent >= CALM_AFTER) calm = 1'b1;
      gappy = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 14) len = $urandom_range(1, 8);
      else if (kind < 18) len = $urandom_range(9, 20);
      else len = $urandom_range(34, 40);
      for (int w = 0; w < len; w++) begin
        if (kind >= 18) begin
          // dense string: every bit is an operator, both counts saturate
          s = {$urandom, $urandom};
          t = ~s;
        end else begin
          s = pick_word();
          t = pick_partner(s);
          if ($urandom_range(0, 1) == 0) begin
            s = t ^ s ^ s;
            t = pick_partner(s);
          end
        end
        send_word(s, t, (w == len - 1) ? 1'b1 : 1'b0);
      end
    end
    item_valid <= 1'b0;
    calm = 1'b1;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
